// ----- rtl/bn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bn_pkg
// Types and constants shared by the batch normalization inference block.
// ----------------------------------------------------------------------------
package bn_pkg;

   // item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // register indexes
   localparam logic CSR_NUM_CHANNELS = 1'b0;
   localparam logic CSR_ROW_LENGTH   = 1'b1;

   // field widths
   localparam int CH_W    = 8;
   localparam int NCH_W   = 9;
   localparam int LEN_W   = 21;
   localparam int ELEM_W  = 20;
   localparam int Q_W     = 16;
   localparam int VAR_W   = 32;
   localparam int ENTRY_W = 3 * Q_W + VAR_W;

   localparam logic [LEN_W-1:0] ROW_LEN_MAX = LEN_W'(1 << ELEM_W);
   localparam int               CH_CAP      = 256;

   typedef struct packed {
      logic                    op;
      logic [CH_W-1:0]         channel_index;
      logic signed [Q_W-1:0]   mean;
      logic [VAR_W-1:0]        variance;
      logic signed [Q_W-1:0]   gamma;
      logic signed [Q_W-1:0]   beta;
      logic signed [Q_W-1:0]   sample;
      logic                    first;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0]   result;
      logic [CH_W-1:0]         channel;
      logic                    saturated;
   } rsp_type;

   // one table entry: mean, variance, gamma, beta
   typedef struct packed {
      logic signed [Q_W-1:0]   mean;
      logic [VAR_W-1:0]        variance;
      logic signed [Q_W-1:0]   gamma;
      logic signed [Q_W-1:0]   beta;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/batchnorm_inference.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batchnorm_inference
// Batch normalization for inference over a channel-major Q8.8 sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries load items (op 0: write one channel's mean, variance,
//   gamma, beta into the parameter RAM) and data items (op 1: one sample).
//   rsp_ channel returns one item per data item: result, channel, saturated.
//   csr_ port writes num_channels (index 0) and row_length (index 1); write
//   only while the block is idle.
// Operation:
//   a data item passes from accept to rsp_valid through one RAM read, a
//   multiply, a square, the bit-serial divider and the square-root unit. One
//   data item is in flight at a time; req_stall is high while it is worked
//   on, so no new item is accepted until its result is in the output
//   register.
// Reset:
//   position counters clear, num_channels and row_length become 1; the
//   parameter RAM holds nothing valid until loaded.
// Stall:
//   a finished item waits in the output register while rsp_stall is high;
//   one new item is still accepted and waits at the final stage behind it.
// ----------------------------------------------------------------------------
module batchnorm_inference #(
   parameter int MAX_CHANNELS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  bn_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output bn_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [20:0]     csr_wdata
);
   import bn_pkg::*;

   localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCH_CAP = (MAX_CHANNELS < CH_CAP) ? MAX_CHANNELS : CH_CAP;

   state_type state_ff, state_in;

   logic [NCH_W-1:0]  nch_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [CH_W-1:0]   cc_ff, cc_in;
   logic [NCH_W-1:0]  nch_eff;
   logic [LEN_W-1:0]  len_eff;
   logic [CH_W-1:0]   ch_cur, ch_ff;
   logic [LEN_W-1:0]  elem_next;
   logic [NCH_W-1:0]  ch_plus;

   logic              accept, load_we, data_acc;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic signed [Q_W-1:0] sample_ff;

   logic signed [16:0] diff;
   logic signed [32:0] prod;
   logic [32:0]        prod_abs;
   logic [30:0]        ap_ff;
   logic               neg_ff;
   logic [32:0]        s_ff;
   logic signed [Q_W-1:0] beta_ff;
   logic [63:0]        t_ff;

   logic               div_start, div_done, sq_start, sq_done;
   logic [63:0]        quo;
   logic [31:0]        root;
   logic [32:0]        qr;
   logic signed [34:0] qs, sum;
   logic               out_free, out_load;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   // effective register values
   always_comb begin
      nch_eff = nch_ff;
      if (nch_ff == '0) begin
         nch_eff = NCH_W'(1);
      end else if (nch_ff > NCH_W'(NCH_CAP)) begin
         nch_eff = NCH_W'(NCH_CAP);
      end
      len_eff = len_ff;
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > ROW_LEN_MAX) begin
         len_eff = ROW_LEN_MAX;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff <= NCH_W'(1);
         len_ff <= LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_CHANNELS: nch_ff <= csr_wdata[NCH_W-1:0];
            CSR_ROW_LENGTH:   len_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign data_acc  = accept && (req_data.op == OP_DATA);
   assign load_we   = accept && (req_data.op == OP_LOAD)
                      && (int'(req_data.channel_index) < MAX_CHANNELS);

   // position tracking for a data item
   always_comb begin
      logic [CH_W-1:0]   cc_s;
      logic [ELEM_W-1:0] el_s;
      cc_s = cc_ff;
      el_s = elem_ff;
      if (req_data.first) begin
         cc_s = '0;
         el_s = '0;
      end
      if ({1'b0, cc_s} >= nch_eff) begin
         cc_s = '0;
      end
      ch_cur    = cc_s;
      elem_next = {1'b0, el_s} + LEN_W'(1);
      ch_plus   = {1'b0, cc_s} + NCH_W'(1);
      elem_in   = elem_ff;
      cc_in     = cc_ff;
      if (data_acc) begin
         if (elem_next >= len_eff) begin
            elem_in = '0;
            cc_in   = (ch_plus >= nch_eff) ? '0 : ch_plus[CH_W-1:0];
         end else begin
            elem_in = elem_next[ELEM_W-1:0];
            cc_in   = cc_s;
         end
      end
   end

   // parameter table
   always_comb begin
      wr_entry.mean     = req_data.mean;
      wr_entry.variance = req_data.variance;
      wr_entry.gamma    = req_data.gamma;
      wr_entry.beta     = req_data.beta;
   end

   bn_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_CHANNELS)
   ) u_table (
      .clock (clock),
      .we    (load_we),
      .waddr (AW'(req_data.channel_index)),
      .wdata (wr_entry),
      .re    (data_acc),
      .raddr (AW'(ch_cur)),
      .rdata (rd_entry)
   );

   // product d*gamma and its magnitude
   always_comb begin
      diff     = 17'(sample_ff) - 17'(rd_entry.mean);
      prod     = diff * 33'(rd_entry.gamma);
      prod_abs = prod[32] ? 33'(-prod) : 33'(prod);
   end

   bn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (t_ff),
      .divisor  (s_ff),
      .quotient (quo),
      .done     (div_done)
   );

   bn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (quo),
      .root     (root),
      .done     (sq_done)
   );

   // rounding, sign, offset and saturation
   always_comb begin
      qr  = ({1'b0, root} + 33'd1) >> 1;
      qs  = neg_ff ? -$signed({2'b00, qr}) : $signed({2'b00, qr});
      sum = qs + 35'(beta_ff);
      rsp_in.channel   = ch_ff;
      rsp_in.saturated = 1'b0;
      rsp_in.result    = sum[Q_W-1:0];
      if (sum > 35'sd32767) begin
         rsp_in.result    = 16'sh7fff;
         rsp_in.saturated = 1'b1;
      end else if (sum < -35'sd32768) begin
         rsp_in.result    = 16'sh8000;
         rsp_in.saturated = 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      sq_start  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      if (data_acc) state_in = ST_READ;
         ST_READ:      state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT:  if (div_done) state_in = ST_SQRT_GO;
         ST_SQRT_GO: begin
            sq_start = 1'b1;
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: if (sq_done) state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elem_ff      <= '0;
         cc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         elem_ff  <= elem_in;
         cc_ff    <= cc_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (data_acc) begin
         sample_ff <= req_data.sample;
         ch_ff     <= ch_cur;
      end
      if (state_ff == ST_READ) begin
         ap_ff   <= prod_abs[30:0];
         neg_ff  <= prod[32];
         s_ff    <= {1'b0, rd_entry.variance} + 33'd1;
         beta_ff <= rd_entry.beta;
      end
      // full 62-bit square, times four
      if (state_ff == ST_SQUARE) begin
         t_ff <= {62'(ap_ff) * 62'(ap_ff), 2'b00};
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- rtl/bn_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ----- rtl/bn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bn_div
// Restoring divider, one quotient bit per cycle, 64-bit by 33-bit.
// ----------------------------------------------------------------------------
module bn_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;
   logic [33:0] diff;

   // one step: shift in next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[32:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

// ----- rtl/bn_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bn_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module bn_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);
   logic [63:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] cur;
   logic [34:0] trial;

   // one step: bring down two bits, trial subtract 4r+1
   always_comb begin
      cur     = {rem_ff[32:0], rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule
